FILE: src/tsd_pkg.sv
// shared types and constants of the double-buffered text screen
// cell layout, operation codes, result record, control states
// no dependencies
`default_nettype none

package tsd_pkg;

  localparam int ROWS_DEF  = 32;
  localparam int COLS_DEF  = 32;

  localparam int CELL_W    = 16;
  localparam int ROW_IDX_W = 7;
  localparam int COL_IDX_W = 6;
  localparam int POS_W     = 5;
  localparam int SYM_W     = 8;
  localparam int COLOR_W   = 4;
  localparam int ATTR_W    = 8;

  // cell: bits 7..0 symbol, 11..8 foreground, 15..12 background
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0700;
  localparam logic [CELL_W-1:0] CLEAR_KEEP = 16'h0F00;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef enum logic {
    KIND_CELL = 1'b0,
    KIND_HOME = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_FLUSH,
    S_FL_END,
    S_FL_DRAIN
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  column;
    logic [SYM_W-1:0]  symbol;
    logic [ATTR_W-1:0] attribute;
  } result_t;

  typedef struct packed {
    logic    push;
    logic    fin;
    result_t res;
  } emit_req_t;

  typedef struct packed {
    logic room;
    logic pend_empty;
  } emit_sts_t;

  function automatic logic [ATTR_W-1:0] cell_attr(input logic [CELL_W-1:0] c);
    cell_attr = {c[15:12], c[11:8]};
  endfunction

endpackage

`default_nettype wire

FILE: src/tsd_cell_mem.sv
// one-write one-read synchronous cell store, registered read data
// depends on tsd_pkg for the cell width
`default_nettype none

module tsd_cell_mem #(
  parameter int DEPTH = tsd_pkg::ROWS_DEF * tsd_pkg::COLS_DEF,
  parameter int AW    = $clog2(tsd_pkg::ROWS_DEF * tsd_pkg::COLS_DEF)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [tsd_pkg::CELL_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [tsd_pkg::CELL_W-1:0]  rdata
);

  logic [tsd_pkg::CELL_W-1:0] mem_r [DEPTH];
  logic [tsd_pkg::CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/tsd_emit.sv
// result staging: one pending result plus the output register
// the pending slot lets the final result of a flush carry last
// depends on tsd_pkg
`default_nettype none

module tsd_emit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tsd_pkg::emit_req_t           req,
  output tsd_pkg::emit_sts_t                sts,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_kind,
  output logic [tsd_pkg::POS_W-1:0]         out_row,
  output logic [tsd_pkg::POS_W-1:0]         out_column,
  output logic [tsd_pkg::SYM_W-1:0]         out_symbol,
  output logic [tsd_pkg::ATTR_W-1:0]        out_attribute,
  output logic                              out_last
);

  logic              pend_valid_r, pend_valid_nxt;
  tsd_pkg::result_t  pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  tsd_pkg::result_t  out_res_r, out_res_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free;
  logic              room;

  assign out_free = !out_valid_r || !out_stall;
  assign room     = !pend_valid_r || out_free;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    out_last_nxt   = out_last_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (req.push && room) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = req.res;
    end else if (req.fin && pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_res_nxt    = pend_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.room       = room;
  assign sts.pend_empty = !pend_valid_r;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_res_r.kind;
  assign out_row       = out_res_r.row;
  assign out_column    = out_res_r.column;
  assign out_symbol    = out_res_r.symbol;
  assign out_attribute = out_res_r.attribute;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

FILE: src/tsd_ctrl.sv
// control sequencer: init pass, draw, clear sweep and row flush
// drives both cell stores and the result staging
// depends on tsd_pkg
`default_nettype none

module tsd_ctrl #(
  parameter int ROWS = tsd_pkg::ROWS_DEF,
  parameter int COLS = tsd_pkg::COLS_DEF,
  parameter int AW   = $clog2(tsd_pkg::ROWS_DEF * tsd_pkg::COLS_DEF)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_operation,
  input  wire logic signed [7:0]             in_row,
  input  wire logic signed [8:0]             in_column,
  input  wire logic [tsd_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic [tsd_pkg::COLOR_W-1:0]   in_fore_color,
  input  wire logic [tsd_pkg::COLOR_W-1:0]   in_back_color,
  output logic                               back_we,
  output logic [AW-1:0]                      back_waddr,
  output logic [tsd_pkg::CELL_W-1:0]         back_wdata,
  output logic                               front_we,
  output logic [AW-1:0]                      front_waddr,
  output logic [tsd_pkg::CELL_W-1:0]         front_wdata,
  output logic                               mem_re,
  output logic [AW-1:0]                      mem_raddr,
  input  wire logic [tsd_pkg::CELL_W-1:0]    back_rdata,
  input  wire logic [tsd_pkg::CELL_W-1:0]    front_rdata,
  output tsd_pkg::emit_req_t                 emit_req,
  input  wire tsd_pkg::emit_sts_t            emit_sts
);

  localparam int CELLS = ROWS * COLS;
  localparam logic [AW-1:0]                 LAST_ADDR = AW'(CELLS - 1);
  localparam logic [tsd_pkg::COL_IDX_W-1:0] LAST_COL  = tsd_pkg::COL_IDX_W'(COLS - 1);
  localparam logic [tsd_pkg::ROW_IDX_W-1:0] LAST_ROW  = tsd_pkg::ROW_IDX_W'(ROWS - 1);
  localparam logic [7:0]                    ROW_LIM   = 8'(ROWS);
  localparam logic [7:0]                    COL_LIM   = 8'(COLS);

  tsd_pkg::state_t                  state_r, state_nxt;
  logic [AW-1:0]                    scan_addr_r, scan_addr_nxt;
  logic [tsd_pkg::COL_IDX_W-1:0]    scan_col_r, scan_col_nxt;
  logic                             scan_on_r, scan_on_nxt;
  logic                             stg_valid_r, stg_valid_nxt;
  logic [AW-1:0]                    stg_addr_r, stg_addr_nxt;
  logic [tsd_pkg::COL_IDX_W-1:0]    stg_col_r, stg_col_nxt;
  logic [tsd_pkg::ROW_IDX_W-1:0]    row_r, row_nxt;
  logic                             frame_changed_r, frame_changed_nxt;

  tsd_pkg::op_t                     op;
  logic                             accept;
  logic                             row_ok;
  logic                             col_ok;
  logic [AW-1:0]                    row_base;
  logic [AW-1:0]                    draw_addr;
  logic                             home_need;
  logic                             differ;
  logic                             blocked;

  assign op        = tsd_pkg::op_t'(in_operation);
  assign in_stall  = (state_r != tsd_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign row_ok    = !in_row[7] && ({1'b0, in_row[6:0]} < ROW_LIM);
  assign col_ok    = !in_column[8] && (in_column[7:0] < COL_LIM);
  assign row_base  = AW'(int'(in_row[6:0]) * COLS);
  assign draw_addr = AW'(int'(in_row[6:0]) * COLS + int'(in_column[7:0]));
  assign home_need = (row_r == LAST_ROW) && frame_changed_r;
  assign differ    = stg_valid_r && (back_rdata != front_rdata);
  assign blocked   = differ && !emit_sts.room;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsd_pkg::S_INIT: begin
        if (scan_addr_r == LAST_ADDR) state_nxt = tsd_pkg::S_IDLE;
      end
      tsd_pkg::S_IDLE: begin
        if (accept) begin
          case (op)
            tsd_pkg::OP_CLEAR: state_nxt = tsd_pkg::S_CLEAR;
            tsd_pkg::OP_FLUSH: if (row_ok) state_nxt = tsd_pkg::S_FLUSH;
            default: state_nxt = tsd_pkg::S_IDLE;
          endcase
        end
      end
      tsd_pkg::S_CLEAR: begin
        if (!scan_on_r && !stg_valid_r) state_nxt = tsd_pkg::S_IDLE;
      end
      tsd_pkg::S_FLUSH: begin
        if (!scan_on_r && !stg_valid_r) state_nxt = tsd_pkg::S_FL_END;
      end
      tsd_pkg::S_FL_END: begin
        if (!home_need || emit_sts.room) state_nxt = tsd_pkg::S_FL_DRAIN;
      end
      tsd_pkg::S_FL_DRAIN: begin
        if (emit_sts.pend_empty) state_nxt = tsd_pkg::S_IDLE;
      end
      default: state_nxt = tsd_pkg::S_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    scan_addr_nxt     = scan_addr_r;
    scan_col_nxt      = scan_col_r;
    scan_on_nxt       = scan_on_r;
    stg_valid_nxt     = stg_valid_r;
    stg_addr_nxt      = stg_addr_r;
    stg_col_nxt       = stg_col_r;
    row_nxt           = row_r;
    frame_changed_nxt = frame_changed_r;
    back_we           = 1'b0;
    back_waddr        = scan_addr_r;
    back_wdata        = tsd_pkg::RESET_CELL;
    front_we          = 1'b0;
    front_waddr       = scan_addr_r;
    front_wdata       = tsd_pkg::RESET_CELL;
    mem_re            = 1'b0;
    mem_raddr         = scan_addr_r;
    emit_req          = '0;
    case (state_r)
      tsd_pkg::S_INIT: begin
        back_we       = 1'b1;
        front_we      = 1'b1;
        scan_addr_nxt = scan_addr_r + AW'(1);
      end
      tsd_pkg::S_IDLE: begin
        if (accept) begin
          case (op)
            tsd_pkg::OP_DRAW: begin
              if (row_ok && col_ok) begin
                back_we    = 1'b1;
                back_waddr = draw_addr;
                back_wdata = {in_back_color, in_fore_color, in_symbol};
              end
            end
            tsd_pkg::OP_CLEAR: begin
              scan_addr_nxt = '0;
              scan_on_nxt   = 1'b1;
            end
            tsd_pkg::OP_FLUSH: begin
              if (row_ok) begin
                row_nxt       = in_row[6:0];
                scan_addr_nxt = row_base;
                scan_col_nxt  = '0;
                scan_on_nxt   = 1'b1;
                if (in_row[6:0] == '0) frame_changed_nxt = 1'b0;
              end
            end
            default: begin
              scan_on_nxt = 1'b0;
            end
          endcase
        end
      end
      tsd_pkg::S_CLEAR: begin
        if (stg_valid_r) begin
          back_we    = 1'b1;
          back_waddr = stg_addr_r;
          back_wdata = back_rdata & tsd_pkg::CLEAR_KEEP;
        end
        mem_re        = scan_on_r;
        stg_valid_nxt = scan_on_r;
        stg_addr_nxt  = scan_addr_r;
        if (scan_on_r) begin
          scan_addr_nxt = scan_addr_r + AW'(1);
          if (scan_addr_r == LAST_ADDR) scan_on_nxt = 1'b0;
        end
      end
      tsd_pkg::S_FLUSH: begin
        if (differ && emit_sts.room) begin
          front_we              = 1'b1;
          front_waddr           = stg_addr_r;
          front_wdata           = back_rdata;
          frame_changed_nxt     = 1'b1;
          emit_req.push         = 1'b1;
          emit_req.res.kind     = tsd_pkg::KIND_CELL;
          emit_req.res.row      = row_r[tsd_pkg::POS_W-1:0];
          emit_req.res.column   = stg_col_r[tsd_pkg::POS_W-1:0];
          emit_req.res.symbol   = back_rdata[tsd_pkg::SYM_W-1:0];
          emit_req.res.attribute = tsd_pkg::cell_attr(back_rdata);
        end
        if (!blocked) begin
          mem_re        = scan_on_r;
          stg_valid_nxt = scan_on_r;
          stg_addr_nxt  = scan_addr_r;
          stg_col_nxt   = scan_col_r;
          if (scan_on_r) begin
            scan_addr_nxt = scan_addr_r + AW'(1);
            scan_col_nxt  = scan_col_r + tsd_pkg::COL_IDX_W'(1);
            if (scan_col_r == LAST_COL) scan_on_nxt = 1'b0;
          end
        end
      end
      tsd_pkg::S_FL_END: begin
        if (home_need) begin
          emit_req.push     = 1'b1;
          emit_req.res.kind = tsd_pkg::KIND_HOME;
        end
      end
      tsd_pkg::S_FL_DRAIN: begin
        emit_req.fin = 1'b1;
      end
      default: begin
        scan_on_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= tsd_pkg::S_INIT;
      scan_addr_r     <= '0;
      scan_on_r       <= 1'b0;
      stg_valid_r     <= 1'b0;
      frame_changed_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      scan_addr_r     <= scan_addr_nxt;
      scan_on_r       <= scan_on_nxt;
      stg_valid_r     <= stg_valid_nxt;
      frame_changed_r <= frame_changed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_col_r <= scan_col_nxt;
    stg_addr_r <= stg_addr_nxt;
    stg_col_r  <= stg_col_nxt;
    row_r      <= row_nxt;
  end

  a_front_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    front_we |-> (state_r == tsd_pkg::S_INIT || state_r == tsd_pkg::S_FLUSH))
    else $error("front store written outside init or flush");

  a_stage_phase: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r |-> (state_r == tsd_pkg::S_CLEAR || state_r == tsd_pkg::S_FLUSH))
    else $error("read stage busy outside a sweep");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsd_pkg::S_FLUSH && scan_on_r) |-> (scan_col_r <= LAST_COL))
    else $error("flush column past row end");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_req.push && state_r == tsd_pkg::S_FLUSH) |-> (emit_sts.room && front_we))
    else $error("cell result pushed without room or front update");

  a_flush_to_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsd_pkg::S_FL_END) |-> ($past(state_r) == tsd_pkg::S_FLUSH ||
                                        $past(state_r) == tsd_pkg::S_FL_END))
    else $error("flush end reached without a row walk");

endmodule

`default_nettype wire

FILE: src/text_screen_diff_buffer.sv
// double-buffered character screen with changed-cell flushing
// input channel: in_valid / in_stall carry draw, clear and flush transactions
// result channel: out_valid / out_stall carry changed cells and cursor home
// after reset the block runs an init pass over both cell stores, holding
// in_stall high until every cell holds the reset cell
// draw: written straight into the back store when accepted
// clear: read-modify-write sweep of the back store
// flush: walks one row through the shared read port, one cell per cycle
// when the receiver keeps up
// each result of a flush passes the pending slot and then the output register;
// the last one is held back one slot so that it can carry out_last
// one transaction is worked on at a time; in_stall is low only when idle
// a stalled receiver freezes the row walk at the first changed cell that
// finds the result slots full; nothing is dropped or repeated
// depends on tsd_pkg, tsd_cell_mem, tsd_emit, tsd_ctrl
`default_nettype none

module text_screen_diff_buffer #(
  parameter int ROWS = tsd_pkg::ROWS_DEF,
  parameter int COLS = tsd_pkg::COLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_operation,
  input  wire logic signed [7:0]             in_row,
  input  wire logic signed [8:0]             in_column,
  input  wire logic [tsd_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic [tsd_pkg::COLOR_W-1:0]   in_fore_color,
  input  wire logic [tsd_pkg::COLOR_W-1:0]   in_back_color,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_kind,
  output logic [tsd_pkg::POS_W-1:0]          out_row,
  output logic [tsd_pkg::POS_W-1:0]          out_column,
  output logic [tsd_pkg::SYM_W-1:0]          out_symbol,
  output logic [tsd_pkg::ATTR_W-1:0]         out_attribute,
  output logic                               out_last
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic                         back_we;
  logic [AW-1:0]                back_waddr;
  logic [tsd_pkg::CELL_W-1:0]   back_wdata;
  logic                         front_we;
  logic [AW-1:0]                front_waddr;
  logic [tsd_pkg::CELL_W-1:0]   front_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [tsd_pkg::CELL_W-1:0]   back_rdata;
  logic [tsd_pkg::CELL_W-1:0]   front_rdata;
  tsd_pkg::emit_req_t           emit_req;
  tsd_pkg::emit_sts_t           emit_sts;

  tsd_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS),
    .AW   (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_row        (in_row),
    .in_column     (in_column),
    .in_symbol     (in_symbol),
    .in_fore_color (in_fore_color),
    .in_back_color (in_back_color),
    .back_we       (back_we),
    .back_waddr    (back_waddr),
    .back_wdata    (back_wdata),
    .front_we      (front_we),
    .front_waddr   (front_waddr),
    .front_wdata   (front_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .back_rdata    (back_rdata),
    .front_rdata   (front_rdata),
    .emit_req      (emit_req),
    .emit_sts      (emit_sts)
  );

  tsd_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_back_mem (
    .clk   (clk),
    .we    (back_we),
    .waddr (back_waddr),
    .wdata (back_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (back_rdata)
  );

  tsd_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_front_mem (
    .clk   (clk),
    .we    (front_we),
    .waddr (front_waddr),
    .wdata (front_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (front_rdata)
  );

  tsd_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (emit_req),
    .sts           (emit_sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_row       (out_row),
    .out_column    (out_column),
    .out_symbol    (out_symbol),
    .out_attribute (out_attribute),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
